// ===== rtl/ctl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types, codes and byte-class helpers for the comment-aware lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

   // token kinds on the result channel
   localparam logic [2:0] KIND_SPACE = 3'd0;
   localparam logic [2:0] KIND_QUOTE = 3'd1;
   localparam logic [2:0] KIND_BLOCK = 3'd2;
   localparam logic [2:0] KIND_LINE  = 3'd3;
   localparam logic [2:0] KIND_PUNCT = 3'd4;
   localparam logic [2:0] KIND_WORD  = 3'd5;

   // lexer modes share the kind encoding
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_QUOTE = 3'd1;
   localparam logic [2:0] MODE_BLOCK = 3'd2;
   localparam logic [2:0] MODE_LINE  = 3'd3;
   localparam logic [2:0] MODE_WORD  = 3'd5;

   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam int QUEUE_DEPTH = 4;

   // one queued job: up to three bytes of a window
   typedef struct packed {
      logic [2:0][7:0] seq;     // seq[0] is the oldest byte
      logic [1:0]      nbytes;  // bytes present in the window (1..3)
      logic            eot;     // window closes the text
   } ctl_job_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] skip;
      logic [1:0] run;
   } ctl_state_type;

   typedef struct packed {
      logic [2:0]    kind;
      logic          start;
      ctl_state_type nxt;
   } ctl_label_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == 8'h2C) || (c == 8'h2E) || (c == 8'h3B) || (c == 8'h5B) ||
             (c == 8'h5D) || (c == 8'h3D) || (c == 8'h2D);
   endfunction

   function automatic ctl_label_type label(input ctl_state_type st,
                                           input logic [7:0] c,
                                           input logic has1, input logic [7:0] c1,
                                           input logic has2, input logic [7:0] c2);
      ctl_label_type r;
      r.kind  = KIND_SPACE;
      r.start = 1'b0;
      r.nxt   = st;
      unique case (st.mode)
         MODE_QUOTE: begin
            r.kind = KIND_QUOTE;
            if (c == CH_QUOTE) r.nxt.mode = MODE_IDLE;
         end
         MODE_BLOCK: begin
            r.kind = KIND_BLOCK;
            if (st.skip != 2'd0) begin
               r.nxt.skip = st.skip - 2'd1;
            end else if (c == CH_SLASH) begin
               if (st.run == 2'd2) begin
                  r.nxt.run  = 2'd0;
                  r.nxt.mode = MODE_IDLE;
               end else begin
                  r.nxt.run = st.run + 2'd1;
               end
            end else begin
               r.nxt.run = 2'd0;
            end
         end
         MODE_LINE: begin
            if (c == CH_CR || c == CH_LF) r.nxt.mode = MODE_IDLE;
            else r.kind = KIND_LINE;
         end
         MODE_WORD: begin
            if (is_space(c)) begin
               r.nxt.mode = MODE_IDLE;
            end else if (is_punct(c)) begin
               r.nxt.mode = MODE_IDLE;
               r.kind     = KIND_PUNCT;
               r.start    = 1'b1;
            end else begin
               r.kind = KIND_WORD;
            end
         end
         default: begin
            // outside any token (unused codes land here too)
            r.nxt.mode = MODE_IDLE;
            if (!is_space(c)) begin
               r.start = 1'b1;
               priority if (c == CH_QUOTE) begin
                  r.kind     = KIND_QUOTE;
                  r.nxt.mode = MODE_QUOTE;
               end else if (c == CH_SLASH && has1 && c1 == CH_SLASH &&
                            has2 && c2 == CH_SLASH) begin
                  r.kind     = KIND_BLOCK;
                  r.nxt.mode = MODE_BLOCK;
                  r.nxt.skip = 2'd2;
                  r.nxt.run  = 2'd0;
               end else if (c == CH_SLASH && has1 && c1 == CH_SLASH) begin
                  r.kind     = KIND_LINE;
                  r.nxt.mode = MODE_LINE;
               end else if (is_punct(c)) begin
                  r.kind = KIND_PUNCT;
               end else begin
                  r.kind     = KIND_WORD;
                  r.nxt.mode = MODE_WORD;
               end
            end
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ctl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_if
// Valid/ready channels for raw text bytes and labeled bytes.
// ----------------------------------------------------------------------------
interface ctl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] token_kind;
   logic       token_start;
   logic       stream_end;
   logic       run_last;

   modport source (output valid, output out_byte, output token_kind,
                   output token_start, output stream_end, output run_last,
                   input ready);
   modport sink   (input valid, input out_byte, input token_kind,
                   input token_start, input stream_end, input run_last,
                   output ready);
endinterface

// ===== rtl/ctl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_front
// Holds two bytes of lookahead and builds byte windows for the back end.
// ----------------------------------------------------------------------------
module ctl_front
   import ctl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ctl_req_if.sink      req,
   input  logic         q_full,
   output logic         push,
   output ctl_job_type  push_job
);

   logic [1:0][7:0] pend_ff, pend_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      pend_in         = pend_ff;
      cnt_in          = cnt_ff;
      push            = 1'b0;
      push_job.seq    = {req.text_byte, pend_ff[1], pend_ff[0]};
      push_job.nbytes = 2'd3;
      push_job.eot    = req.end_of_text;
      if (accept) begin
         if (!req.end_of_text) begin
            if (cnt_ff != 2'd2) begin
               pend_in[cnt_ff[0]] = req.text_byte;
               cnt_in             = cnt_ff + 2'd1;
            end else begin
               push       = 1'b1;
               pend_in[0] = pend_ff[1];
               pend_in[1] = req.text_byte;
            end
         end else begin
            // flush: the window holds the pending bytes then this one
            push            = 1'b1;
            cnt_in          = 2'd0;
            push_job.nbytes = cnt_ff + 2'd1;
            unique case (cnt_ff)
               2'd0:    push_job.seq = {8'h00, 8'h00, req.text_byte};
               2'd1:    push_job.seq = {8'h00, req.text_byte, pend_ff[0]};
               default: push_job.seq = {req.text_byte, pend_ff[1], pend_ff[0]};
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/ctl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_queue
// Short job FIFO between the window builder and the labeler.
// ----------------------------------------------------------------------------
module ctl_queue
   import ctl_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ctl_job_type                push_job,
   input  logic                       pop,
   output logic                       full,
   output logic                       head_valid,
   output ctl_job_type                head_job,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ctl_job_type   mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == CW'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = mem_ff[rd_ff];
   assign count      = cnt_ff;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (!push && pop) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/ctl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_back
// Labels one byte of the head window per cycle unless the output register is held, and drives it.
// ----------------------------------------------------------------------------
module ctl_back
   import ctl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  ctl_job_type  head_job,
   output logic         pop,
   ctl_rsp_if.source    rsp
);

   ctl_state_type st_ff, st_in;
   logic [1:0]    k_ff, k_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    byte_ff;
   logic [2:0]    kind_ff;
   logic          start_ff, end_ff, last_ff;
   logic          step, last, has1, has2;
   logic [7:0]    c, c1;
   logic [2:0]    k_ext, n_ext;
   ctl_label_type lab;

   assign k_ext = {1'b0, k_ff};
   assign n_ext = {1'b0, head_job.nbytes};
   assign has1  = (k_ext + 3'd1) < n_ext;
   assign has2  = (k_ext + 3'd2) < n_ext;
   assign last  = head_job.eot ? ((k_ext + 3'd1) == n_ext) : 1'b1;
   assign step  = head_valid && (!out_valid_ff || rsp.ready);
   assign pop   = step && last;

   always_comb begin
      unique case (k_ff)
         2'd0:    begin c = head_job.seq[0]; c1 = head_job.seq[1]; end
         2'd1:    begin c = head_job.seq[1]; c1 = head_job.seq[2]; end
         default: begin c = head_job.seq[2]; c1 = 8'h00;           end
      endcase
      lab = label(st_ff, c, has1, c1, has2, head_job.seq[2]);
   end

   always_comb begin
      st_in        = st_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (step) begin
         out_valid_in = 1'b1;
         st_in        = lab.nxt;
         k_in         = k_ff + 2'd1;
         if (last) begin
            k_in = 2'd0;
            // end of text returns the lexer to its idle state
            if (head_job.eot) st_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff  <= c;
         kind_ff  <= lab.kind;
         start_ff <= lab.start;
         end_ff   <= head_job.eot && last;
         last_ff  <= last;
      end
      if (reset) begin
         st_ff        <= '0;
         k_ff         <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.token_kind  = kind_ff;
   assign rsp.token_start = start_ff;
   assign rsp.stream_end  = end_ff;
   assign rsp.run_last    = last_ff;

endmodule

// ===== rtl/comment_aware_token_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_aware_token_lexer
// Labels text bytes with token kind and start flag, two bytes of lookahead.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | rule
//  req     | in  | text_byte, end_of_text                           | valid&ready
//  rsp     | out | out_byte, token_kind, token_start, stream_end,   | valid&ready
//          |     | run_last                                         |
//
// One request accepted per cycle unless the queue is full, one labeled byte out
// per cycle unless rsp stalls; a final byte flushing n pending bytes holds the
// labeler for n+1 bytes. A result passes the job queue, then the output reg.
// Synchronous active-high reset clears the counters, queue and lexer mode.
// req.ready drops only while the job queue is full; a waiting result stalls
// the labeler while the queue takes up the slack.
// ----------------------------------------------------------------------------
module comment_aware_token_lexer
   import ctl_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   ctl_req_if.sink   req,
   ctl_rsp_if.source rsp
);

   logic                        q_full, push, pop, head_valid;
   ctl_job_type                 push_job, head_job;
   logic [$clog2(QDEPTH+1)-1:0] q_count;

   ctl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   ctl_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .count      (q_count)
   );

   ctl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QDEPTH+1))'(QDEPTH))
      else $error("job queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty job queue");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.stream_end |-> rsp.run_last)
      else $error("stream end without run_last");

   a_start_not_space: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.token_start |-> rsp.token_kind != KIND_SPACE)
      else $error("token start on whitespace");

endmodule

// ===== bench/tb_comment_aware_token_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_comment_aware_token_lexer
// Feeds short texts byte by byte, with end_of_text on each final byte, and
// checks every labeled byte against a behavioral lexer kept in the bench.
// Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb_comment_aware_token_lexer;
   import ctl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 200;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic [7:0] ch;
      logic [2:0] kind;
      logic       start;
      logic       text_end;
      logic       run_end;
   } byte_label_type;

   class token_labeler;
      logic [7:0]     held [2];
      int unsigned    held_n;
      logic [2:0]     mode;
      logic [1:0]     slash_seen;
      logic [1:0]     opener_left;
      byte_label_type expected_labels [$];
      int unsigned    mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         held_n      = 0;
         mode        = MODE_IDLE;
         slash_seen  = 2'd0;
         opener_left = 2'd0;
      endfunction

      function bit blank(input logic [7:0] c);
         return c inside {8'h20, [8'h09:8'h0D]};
      endfunction

      function bit single_punct(input logic [7:0] c);
         return c inside {",", ".", ";", "[", "]", "=", "-"};
      endfunction

      // labels c with up to two bytes of lookahead and advances the mode
      function void classify(input logic [7:0] c, input bit has1, input logic [7:0] c1,
                             input bit has2, input logic [7:0] c2,
                             output logic [2:0] kind, output logic start);
         kind  = KIND_SPACE;
         start = 1'b0;
         case (mode)
            MODE_QUOTE: begin
               kind = KIND_QUOTE;
               if (c == CH_QUOTE) mode = MODE_IDLE;
               return;
            end
            MODE_BLOCK: begin
               kind = KIND_BLOCK;
               if (opener_left != 2'd0) begin
                  opener_left = opener_left - 2'd1;
               end else if (c == CH_SLASH) begin
                  if (slash_seen == 2'd2) begin
                     slash_seen = 2'd0;
                     mode       = MODE_IDLE;
                  end else begin
                     slash_seen = slash_seen + 2'd1;
                  end
               end else begin
                  slash_seen = 2'd0;
               end
               return;
            end
            MODE_LINE: begin
               if (c == CH_CR || c == CH_LF) mode = MODE_IDLE;
               else kind = KIND_LINE;
               return;
            end
            MODE_WORD: begin
               if (blank(c)) begin
                  mode = MODE_IDLE;
               end else if (single_punct(c)) begin
                  mode  = MODE_IDLE;
                  kind  = KIND_PUNCT;
                  start = 1'b1;
               end else begin
                  kind = KIND_WORD;
               end
               return;
            end
            default: ;
         endcase
         mode = MODE_IDLE;
         if (blank(c)) return;
         start = 1'b1;
         if (c == CH_QUOTE) begin
            kind = KIND_QUOTE;
            mode = MODE_QUOTE;
         end else if (c == CH_SLASH && has1 && c1 == CH_SLASH && has2 && c2 == CH_SLASH) begin
            kind        = KIND_BLOCK;
            mode        = MODE_BLOCK;
            opener_left = 2'd2;
            slash_seen  = 2'd0;
         end else if (c == CH_SLASH && has1 && c1 == CH_SLASH) begin
            kind = KIND_LINE;
            mode = MODE_LINE;
         end else if (single_punct(c)) begin
            kind = KIND_PUNCT;
         end else begin
            kind = KIND_WORD;
            mode = MODE_WORD;
         end
      endfunction

      function void add_expected(input byte_label_type lbl);
         expected_labels = {expected_labels, lbl};
      endfunction

      function void take_byte(input logic [7:0] b, input logic eot);
         byte_label_type lbl;
         logic [7:0]     seq [3];
         int             n;
         int             i;
         bit             h1, h2;
         if (!eot) begin
            if (held_n < 2) begin
               held[held_n] = b;
               held_n++;
               return;
            end
            classify(held[0], 1'b1, held[1], 1'b1, b, lbl.kind, lbl.start);
            lbl.ch       = held[0];
            lbl.text_end = 1'b0;
            lbl.run_end  = 1'b1;
            add_expected(lbl);
            held[0] = held[1];
            held[1] = b;
            return;
         end
         // final byte: flush everything held plus this one
         n = 0;
         for (i = 0; i < held_n; i++) begin
            seq[n] = held[i];
            n++;
         end
         seq[n] = b;
         n++;
         for (i = 0; i < n; i++) begin
            h1 = (i + 1 < n);
            h2 = (i + 2 < n);
            classify(seq[i], h1, h1 ? seq[i + 1] : 8'h00, h2, h2 ? seq[i + 2] : 8'h00,
                     lbl.kind, lbl.start);
            lbl.ch       = seq[i];
            lbl.text_end = (i + 1 == n);
            lbl.run_end  = (i + 1 == n);
            add_expected(lbl);
         end
         clear();
      endfunction

      function void match_label(input byte_label_type got);
         byte_label_type want;
         if (expected_labels.size() == 0) begin
            $error("unexpected result: out_byte %0h kind %0d", got.ch, got.kind);
            mismatches++;
            return;
         end
         want = expected_labels.pop_front();
         if (want.ch !== got.ch) begin
            $error("out_byte: expected %0h, actual %0h", want.ch, got.ch);
            mismatches++;
         end
         if (want.kind !== got.kind) begin
            $error("token_kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
         end
         if (want.start !== got.start) begin
            $error("token_start: expected %0b, actual %0b", want.start, got.start);
            mismatches++;
         end
         if (want.text_end !== got.text_end) begin
            $error("stream_end: expected %0b, actual %0b", want.text_end, got.text_end);
            mismatches++;
         end
         if (want.run_end !== got.run_end) begin
            $error("run_last: expected %0b, actual %0b", want.run_end, got.run_end);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ctl_req_if req_ch ();
   ctl_rsp_if rsp_ch ();

   comment_aware_token_lexer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   token_labeler book = new();
   logic [7:0]   text_q [$];
   int           burst_left = 0;
   int           items_sent = 0;
   int           cycles = 0;
   int           rx_count = 0;
   int           rx_style = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_comment_aware_token_lexer: done, errors");
         $finish;
      end
   end

   // receiver: ready follows one of four stall styles, redrawn at random
   always @(negedge clock) begin
      if (rx_count % 40 == 0) rx_style = $urandom_range(0, 3);
      rx_count++;
      case (rx_style)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
         2:       rsp_ch.ready <= (rx_count % 3 == 0);
         default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   always @(posedge clock) begin
      byte_label_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.ch       = rsp_ch.out_byte;
         got.kind     = rsp_ch.token_kind;
         got.start    = rsp_ch.token_start;
         got.text_end = rsp_ch.stream_end;
         got.run_end  = rsp_ch.run_last;
         book.match_label(got);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 4);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_byte   <= b;
      req_ch.end_of_text <= eot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      book.take_byte(b, eot);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      items_sent += text_q.size();
      text_q = {};
   endtask

   function automatic void add_byte(input logic [7:0] b);
      text_q = {text_q, b};
   endfunction

   function automatic void push_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] any_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   // appends one token-shaped piece; most pieces are well formed
   function automatic void add_piece();
      int          n;
      int          i;
      logic [7:0]  blanks [6];
      logic [7:0]  puncts [7];
      blanks = '{8'h20, 8'h09, CH_LF, CH_CR, 8'h0B, 8'h0C};
      puncts = '{",", ".", ";", "[", "]", "=", "-"};
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(0, 7))
                  0:       add_byte(CH_SLASH);
                  1:       add_byte(CH_QUOTE);
                  2:       add_byte(8'($urandom_range(128, 255)));
                  default: add_byte(any_letter());
               endcase
            end
         end
         2: begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++) add_byte(blanks[$urandom_range(0, 5)]);
         end
         3: add_byte(puncts[$urandom_range(0, 6)]);
         4: begin
            add_byte(CH_QUOTE);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) add_byte(CH_QUOTE);
         end
         5: begin
            push_str("//");
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
         end
         6: begin
            push_str("///");
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 2) == 0) add_byte(CH_SLASH);
               else add_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 4) != 0) push_str("///");
         end
         7: add_byte(8'($urandom_range(0, 255)));
         8: begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++) add_byte(CH_SLASH);
         end
         default: add_byte(8'h20);
      endcase
   endfunction

   initial begin
      int target;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.text_byte   = 8'h00;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single high byte: a one-byte word, flushed at once
      add_byte(8'hFF);
      send_text();
      // slash pair at end of text opens a line comment
      push_str("//");
      send_text();
      // slash and quote do not end a word
      push_str("a/',");
      send_text();
      // block comment whose opener slashes are not counted toward the close
      push_str("///x///");
      send_text();
      // line comment stops at CR, then an unclosed quote
      push_str("// ");
      add_byte(CH_CR);
      add_byte(CH_QUOTE);
      send_text();
      add_byte(8'h00);
      add_byte(8'h20);
      push_str("-");
      add_byte(8'h80);
      add_byte(8'h7F);
      send_text();

      items_sent = 0;
      while (items_sent < RANDOM_BYTES) begin
         target = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
         while (text_q.size() < target) add_piece();
         send_text();
      end
      req_ch.valid <= 1'b0;

      while (book.expected_labels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0) begin
         $display("tb_comment_aware_token_lexer: done, clean");
      end else begin
         $display("tb_comment_aware_token_lexer: done, errors");
      end
      $finish;
   end

endmodule

// ===== comment_aware_token_lexer.f =====
rtl/ctl_pkg.sv
rtl/ctl_if.sv
rtl/ctl_front.sv
rtl/ctl_queue.sv
rtl/ctl_back.sv
rtl/comment_aware_token_lexer.sv
bench/tb_comment_aware_token_lexer.sv
